### sv/assert_macros.svh
// Assertion macros shared by the step counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PVSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PVSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pvsc_pkg.sv
// Package with widths, codes and types of the peak/valley step counter.
`default_nettype none
package pvsc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int POS_WIDTH    = 16;
  localparam int KIND_WIDTH   = 2;
  localparam int HELD_WIDTH   = 2;
  localparam int ADDR_WIDTH   = 3;
  localparam int DATA_WIDTH   = 32;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;
  typedef logic [POS_WIDTH-1:0]           pos_t;
  typedef logic [KIND_WIDTH-1:0]          kind_t;
  typedef logic [HELD_WIDTH-1:0]          held_t;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_HIGH = 2'd1;
  localparam kind_t KIND_LOW  = 2'd2;

  localparam logic REG_PEAK = 1'b0;
  localparam logic REG_LOW  = 1'b1;

  localparam held_t HELD_EMPTY = 2'd0;
  localparam held_t HELD_ONE   = 2'd1;
  localparam held_t HELD_FULL  = 2'd2;

  localparam pos_t POS_MAX = {POS_WIDTH{1'b1}};

  typedef struct packed {
    sample_t peak;
    sample_t low;
  } thresh_t;

  typedef struct packed {
    kind_t  kind;
    logic   found;
    logic   seeking_next;
    count_t steps_next;
  } cls_t;

endpackage
`default_nettype wire

### sv/pvsc_cfg.sv
// APB-style register block holding the peak and low thresholds.
`default_nettype none
module pvsc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pvsc_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [pvsc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic      [pvsc_pkg::DATA_WIDTH-1:0] prdata,
  output pvsc_pkg::thresh_t                    thresh
);

  logic reg_index;
  logic write_en;

  assign reg_index = paddr[2];
  assign write_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= '0;
    end else if (write_en) begin
      case (reg_index)
        pvsc_pkg::REG_PEAK: thresh.peak <= pvsc_pkg::sample_t'(pwdata[pvsc_pkg::SAMPLE_WIDTH-1:0]);
        pvsc_pkg::REG_LOW:  thresh.low  <= pvsc_pkg::sample_t'(pwdata[pvsc_pkg::SAMPLE_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  // Reads return the threshold sign-extended to the data width.
  always_comb begin
    case (reg_index)
      pvsc_pkg::REG_PEAK: prdata = pvsc_pkg::DATA_WIDTH'(thresh.peak);
      pvsc_pkg::REG_LOW:  prdata = pvsc_pkg::DATA_WIDTH'(thresh.low);
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### sv/pvsc_classify.sv
// Classifies the middle sample of the window and updates the step search.
`default_nettype none
module pvsc_classify (
  input  wire pvsc_pkg::sample_t older,
  input  wire pvsc_pkg::sample_t middle,
  input  wire pvsc_pkg::sample_t newest,
  input  wire pvsc_pkg::thresh_t thresh,
  input  wire logic              seeking,
  input  wire pvsc_pkg::count_t  steps,
  output pvsc_pkg::cls_t         cls
);

  logic is_high;
  logic is_low;

  // A sample meeting both conditions is a high peak.
  assign is_high = (older <= middle) && (newest <= middle) && (middle > thresh.peak);
  assign is_low  = (older >= middle) && (newest >= middle) && (middle < thresh.low);

  always_comb begin
    cls.kind         = pvsc_pkg::KIND_NONE;
    cls.found        = 1'b0;
    cls.seeking_next = seeking;
    cls.steps_next   = steps;
    if (is_high) begin
      cls.kind         = pvsc_pkg::KIND_HIGH;
      cls.seeking_next = 1'b1;
    end else if (is_low) begin
      cls.kind = pvsc_pkg::KIND_LOW;
      if (seeking) begin
        cls.found        = 1'b1;
        cls.seeking_next = 1'b0;
        cls.steps_next   = steps + pvsc_pkg::count_t'(1);
      end
    end
  end

endmodule
`default_nettype wire

### sv/peak_valley_step_counter.sv
// Top level of the peak/valley step counter: input stage, window state and result register.
`default_nettype none
// The block takes one signed Q8.8 acceleration sample per beat and reports, one
// sample later, whether the previous sample was a high peak, a low valley or
// nothing, together with its position in the record and the running step count.
// A step is counted at the first low valley that follows a high peak. The first
// two samples of a record (first set) give no result beat, and the last sample
// of a record is never classified since it has no successor. The sustained rate
// is one sample per clock cycle while results are taken: a sample is registered
// at the input stage, and from there the classifier (six compares and a count
// increment) runs between that stage and the window state, writing the result
// register. The result register and the input stage both hold a beat, so a
// stalled result does not stop a new sample from being taken in; the input
// stage waits only when it holds a sample that yields a result while the
// result register is still full.
// Thresholds are written through the APB-style port at byte addresses 0 (peak)
// and 4 (low), and should only be changed while no sample is in flight.
module peak_valley_step_counter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Sample channel.
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire pvsc_pkg::sample_t               sample,
  input  wire logic                            first,
  input  wire logic                            clear_count,
  // Result channel.
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output pvsc_pkg::pos_t                       position,
  output pvsc_pkg::kind_t                      kind,
  output logic                                 step_found,
  output pvsc_pkg::count_t                     step_count,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pvsc_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [pvsc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic      [pvsc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                                 pready
);

  pvsc_pkg::thresh_t thresh;

  // Input stage.
  logic              s1_valid;
  pvsc_pkg::sample_t s1_sample;
  logic              s1_first;
  logic              s1_clear;

  // Window and search state.
  pvsc_pkg::sample_t older_sample;
  pvsc_pkg::sample_t middle_sample;
  pvsc_pkg::held_t   samples_held;
  pvsc_pkg::pos_t    middle_position;
  logic              seeking_low;
  pvsc_pkg::count_t  steps;

  // State as seen by the staged sample once its first and clear_count flags apply.
  pvsc_pkg::held_t   held_eff;
  logic              seek_eff;
  pvsc_pkg::count_t  steps_eff;
  logic              s1_produces;
  logic              s1_advance;
  pvsc_pkg::cls_t    cls;

  assign pready = 1'b1;

  pvsc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .thresh  (thresh)
  );

  assign held_eff  = s1_first ? pvsc_pkg::HELD_EMPTY : samples_held;
  assign seek_eff  = s1_first ? 1'b0 : seeking_low;
  assign steps_eff = s1_clear ? '0 : steps;

  // A held count of three cannot arise; the upper bit alone marks a full window.
  assign s1_produces = held_eff[1];

  // A sample that fills the window needs no room in the result register.
  assign s1_advance   = s1_valid && (!s1_produces || !result_valid || result_ready);
  assign sample_ready = !s1_valid || s1_advance;

  pvsc_classify u_classify (
    .older   (older_sample),
    .middle  (middle_sample),
    .newest  (s1_sample),
    .thresh  (thresh),
    .seeking (seek_eff),
    .steps   (steps_eff),
    .cls     (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      s1_sample <= sample;
      s1_first  <= first;
      s1_clear  <= clear_count;
    end
  end

  // Window update. The samples need no reset: the held count gates their use.
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_held    <= pvsc_pkg::HELD_EMPTY;
      middle_position <= '0;
      seeking_low     <= 1'b0;
      steps           <= '0;
    end else if (s1_advance) begin
      steps <= s1_produces ? cls.steps_next : steps_eff;
      case (held_eff)
        pvsc_pkg::HELD_EMPTY: begin
          samples_held    <= pvsc_pkg::HELD_ONE;
          middle_position <= s1_first ? '0 : middle_position;
          seeking_low     <= seek_eff;
        end
        pvsc_pkg::HELD_ONE: begin
          samples_held    <= pvsc_pkg::HELD_FULL;
          middle_position <= pvsc_pkg::pos_t'(1);
          seeking_low     <= seek_eff;
        end
        default: begin
          samples_held    <= pvsc_pkg::HELD_FULL;
          seeking_low     <= cls.seeking_next;
          if (middle_position != pvsc_pkg::POS_MAX) begin
            middle_position <= middle_position + pvsc_pkg::pos_t'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      case (held_eff)
        pvsc_pkg::HELD_EMPTY: older_sample <= s1_sample;
        pvsc_pkg::HELD_ONE:   middle_sample <= s1_sample;
        default: begin
          older_sample  <= middle_sample;
          middle_sample <= s1_sample;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && s1_produces) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_produces) begin
      position   <= middle_position;
      kind       <= cls.kind;
      step_found <= cls.found;
      step_count <= cls.steps_next;
    end
  end

`include "assert_macros.svh"

  `PVSC_ASSERT_NOW(a_step_is_low, result_valid && step_found, kind == pvsc_pkg::KIND_LOW, "step reported on a sample that is not a low valley")
  `PVSC_ASSERT_NOW(a_pos_nonzero, result_valid, position != '0, "result beat at record position zero")
  `PVSC_ASSERT_NOW(a_held_range, 1'b1, samples_held != 2'd3, "window held count out of range")
  `PVSC_ASSERT_NEXT(a_no_overwrite, result_valid && !result_ready && s1_valid && s1_produces, result_valid && !s1_advance || !s1_produces || !s1_valid || result_ready, "stalled result overwritten")

endmodule
`default_nettype wire
